/* rtl/core/lpfd_pkg.sv */
package lpfd_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned LenW  = 16;

    typedef enum logic [3:0] {
        PH_LEN_LO = 4'b0001,
        PH_LEN_HI = 4'b0010,
        PH_ID     = 4'b0100,
        PH_DATA   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [ByteW-1:0] board_code;
        logic             identified;
        logic [ByteW-1:0] message_id;
        logic [ByteW-1:0] data_byte;
        logic             has_data;
        logic             last;
        logic             bad_length;
    } t_result;

endpackage

/* rtl/core/lpfd_if.sv */
interface lpfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] board_id_code;

    modport source (output valid, output board_id_code, input ready);
    modport sink   (input valid, input board_id_code, output ready);
endinterface

interface lpfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] board_code;
    logic       identified;
    logic [7:0] message_id;
    logic [7:0] data_byte;
    logic       has_data;
    logic       last;
    logic       bad_length;

    modport source (
        output valid, output board_code, output identified, output message_id,
        output data_byte, output has_data, output last, output bad_length,
        input ready
    );
    modport sink (
        input valid, input board_code, input identified, input message_id,
        input data_byte, input has_data, input last, input bad_length,
        output ready
    );
endinterface

/* rtl/core/lpfd_parser.sv */
module lpfd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output lpfd_pkg::t_result o_res
);
    import lpfd_pkg::*;

    t_phase            r_phase, n_phase;
    logic [ByteW-1:0]  r_length_low, n_length_low;
    logic [LenW-1:0]   r_remaining, n_remaining;
    logic [ByteW-1:0]  r_frame_id, n_frame_id;
    logic              r_capture, n_capture;
    logic [ByteW-1:0]  r_board_value, n_board_value;
    logic              r_board_known, n_board_known;
    logic [ByteW-1:0]  r_board_id_code;
    logic [LenW-1:0]   w_len;
    logic [LenW-1:0]   w_rem_dec;

    assign w_len     = {i_byte, r_length_low};
    assign w_rem_dec = r_remaining - LenW'(1);

    always_comb begin
        n_phase       = r_phase;
        n_length_low  = r_length_low;
        n_remaining   = r_remaining;
        n_frame_id    = r_frame_id;
        n_capture     = r_capture;
        n_board_value = r_board_value;
        n_board_known = r_board_known;
        o_res_valid   = 1'b0;
        o_res         = '0;
        unique case (r_phase)
            PH_LEN_LO: begin
                n_length_low = i_byte;
                n_phase      = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                if (w_len == '0) begin
                    n_phase          = PH_LEN_LO;
                    o_res_valid      = 1'b1;
                    o_res.last       = 1'b1;
                    o_res.bad_length = 1'b1;
                end else begin
                    n_remaining = w_len - LenW'(1);
                    n_phase     = PH_ID;
                end
            end
            PH_ID: begin
                n_frame_id = i_byte;
                n_capture  = (i_byte == r_board_id_code) && (r_remaining == LenW'(1));
                if (r_remaining == '0) begin
                    n_phase          = PH_LEN_LO;
                    o_res_valid      = 1'b1;
                    o_res.message_id = i_byte;
                    o_res.last       = 1'b1;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (r_capture) begin
                    n_board_value = i_byte;
                    n_board_known = 1'b1;
                end
                n_remaining = w_rem_dec;
                if (w_rem_dec == '0) begin
                    n_phase = PH_LEN_LO;
                end
                o_res_valid      = 1'b1;
                o_res.message_id = r_frame_id;
                o_res.data_byte  = i_byte;
                o_res.has_data   = 1'b1;
                o_res.last       = (w_rem_dec == '0);
            end
            default: begin
                n_phase = PH_LEN_LO;
            end
        endcase
        o_res.board_code = n_board_value;
        o_res.identified = n_board_known;
        if (!i_accept) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_LEN_LO;
            r_length_low    <= '0;
            r_remaining     <= '0;
            r_frame_id      <= '0;
            r_capture       <= 1'b0;
            r_board_value   <= '0;
            r_board_known   <= 1'b0;
            r_board_id_code <= '0;
        end else begin
            if (i_cfg_we) begin
                r_board_id_code <= i_cfg_data;
            end
            if (i_accept) begin
                r_phase       <= n_phase;
                r_length_low  <= n_length_low;
                r_remaining   <= n_remaining;
                r_frame_id    <= n_frame_id;
                r_capture     <= n_capture;
                r_board_value <= n_board_value;
                r_board_known <= n_board_known;
            end
        end
    end

endmodule

/* rtl/core/lpfd_out_skid.sv */
module lpfd_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lpfd_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_valid,
    output lpfd_pkg::t_result o_data,
    input  logic              i_ready
);
    import lpfd_pkg::*;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    w_load;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign w_load  = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid  <= r_skid_valid || i_push;
                r_skid_valid <= 1'b0;
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

/* rtl/core/length_prefixed_frame_deframer.sv */
// The result of an accepted word is registered in the output stage, or in the skid stage while the output stalls.
// Throughput: one word per cycle while input ready is high; the parser state register updates once per accepted word.
// Input ready drops only when the output register and its skid stage both hold a result.
// Reset (synchronous, active low) returns the parser to the length low byte, clears the
// captured board id, identified flag and board_id_code, and empties the output stages.
module length_prefixed_frame_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpfd_in_if.sink    i_rx,
    lpfd_cfg_if.sink   i_cfg,
    lpfd_out_if.source o_res
);
    import lpfd_pkg::*;

    logic    w_accept;
    logic    w_in_ready;
    logic    w_push;
    t_result w_res;
    logic    w_out_valid;
    t_result w_out;

    assign i_cfg.ready = 1'b1;
    assign i_rx.ready  = w_in_ready;
    assign w_accept    = i_rx.valid && w_in_ready;

    lpfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_data  (i_cfg.board_id_code),
        .i_accept    (w_accept),
        .i_byte      (i_rx.rx_byte),
        .o_res_valid (w_push),
        .o_res       (w_res)
    );

    lpfd_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_ready (w_in_ready),
        .o_valid (w_out_valid),
        .o_data  (w_out),
        .i_ready (o_res.ready)
    );

    assign o_res.valid      = w_out_valid;
    assign o_res.board_code = w_out.board_code;
    assign o_res.identified = w_out.identified;
    assign o_res.message_id = w_out.message_id;
    assign o_res.data_byte  = w_out.data_byte;
    assign o_res.has_data   = w_out.has_data;
    assign o_res.last       = w_out.last;
    assign o_res.bad_length = w_out.bad_length;

`ifndef SYNTHESIS
    a_stall_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_ready |-> w_out_valid)
        else $error("input stalled with no pending result");

    a_bad_has_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_valid && w_out.bad_length |-> !w_out.has_data && w_out.last)
        else $error("dropped frame result carries data");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_valid && !w_out.has_data |-> w_out.last)
        else $error("result without data not marked last");
`endif

endmodule

/* dv/tb_length_prefixed_frame_deframer.sv */
module tb_length_prefixed_frame_deframer;

    import lpfd_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lpfd_in_if  rx_if();
    lpfd_cfg_if cfg_if();
    lpfd_out_if res_if();

    length_prefixed_frame_deframer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // deframer state as the block should hold it
    logic [7:0]  id_code;
    t_phase      ph;
    logic [7:0]  len_lo;
    logic [15:0] left;
    logic [7:0]  frame_id;
    logic        capture;
    logic [7:0]  board_value;
    logic        board_known;

    t_result     expected_results[$];
    logic [7:0]  rx_words[$];
    logic        rx_taken = 1'b0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          words_pushed = 0;
    int          words_taken = 0;
    int          results_checked = 0;
    int          mismatches = 0;
    int          frames_done = 0;
    int          dropped = 0;
    int          captured = 0;
    int          cfg_writes = 0;

    function automatic void push_result(input logic [7:0] id, input logic [7:0] data,
                                        input logic has, input logic fin, input logic bad);
        t_result r;
        r.board_code = board_value;
        r.identified = board_known;
        r.message_id = id;
        r.data_byte  = data;
        r.has_data   = has;
        r.last       = fin;
        r.bad_length = bad;
        expected_results = {expected_results, r};
        if (fin) frames_done++;
    endfunction

    function automatic void deframe_word(input logic [7:0] w);
        logic [15:0] len;
        case (ph)
            PH_LEN_LO: begin
                len_lo = w;
                ph = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len = {w, len_lo};
                if (len == 16'd0) begin
                    ph = PH_LEN_LO;
                    dropped++;
                    push_result(8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
                end else begin
                    left = len - 16'd1;
                    ph = PH_ID;
                end
            end
            PH_ID: begin
                frame_id = w;
                capture = (w == id_code) && (left == 16'd1);
                if (left == 16'd0) begin
                    ph = PH_LEN_LO;
                    push_result(frame_id, 8'h00, 1'b0, 1'b1, 1'b0);
                end else begin
                    ph = PH_DATA;
                end
            end
            default: begin
                if (capture) begin
                    board_value = w;
                    board_known = 1'b1;
                    captured++;
                end
                left = left - 16'd1;
                if (left == 16'd0) ph = PH_LEN_LO;
                push_result(frame_id, w, 1'b1, left == 16'd0, 1'b0);
            end
        endcase
    endfunction

    function automatic string describe_result(input t_result r);
        return $sformatf("board=%h ident=%b id=%h data=%h has=%b last=%b bad=%b",
                         r.board_code, r.identified, r.message_id, r.data_byte,
                         r.has_data, r.last, r.bad_length);
    endfunction

    function automatic void add_word(input logic [7:0] w);
        rx_words = {rx_words, w};
        words_pushed++;
    endfunction

    // payload bytes are random
    function automatic void add_frame(input logic [15:0] len, input logic [7:0] id);
        add_word(len[7:0]);
        add_word(len[15:8]);
        if (len != 16'd0) begin
            add_word(id);
            for (int i = 1; i < len; i++) add_word(8'($urandom_range(255)));
        end
    endfunction

    function automatic void add_random_frame();
        int         pick;
        logic [7:0] id;
        pick = $urandom_range(99);
        id = 8'($urandom_range(255));
        if (pick < 6) add_frame(16'd0, id);
        else if (pick < 14) add_frame(16'd1, id);
        else if (pick < 30) add_frame(16'd2, id_code);
        else if (pick < 36) add_frame(16'($urandom_range(6, 3)), id_code);
        else if (pick < 97) add_frame(16'($urandom_range(12, 2)), id);
        else add_frame(16'($urandom_range(64, 13)), id);
    endfunction

    task automatic wait_drained();
        while (words_taken != words_pushed || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_board_id_code(input logic [7:0] v);
        @(negedge i_clk);
        cfg_if.valid         <= 1'b1;
        cfg_if.board_id_code <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int words);
        int start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = words_pushed;
        while (words_pushed - start < words / 2) add_random_frame();
        // sender holds off until the block has drained
        wait_drained();
        while (words_pushed - start < words) add_random_frame();
        wait_drained();
    endtask

    // word driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
        end else if (!rx_if.valid || rx_taken) begin
            if (rx_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                rx_if.valid   <= 1'b1;
                rx_if.rx_byte <= rx_words.pop_front();
            end else begin
                rx_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        rx_taken = 1'b0;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got.board_code = res_if.board_code;
                got.identified = res_if.identified;
                got.message_id = res_if.message_id;
                got.data_byte  = res_if.data_byte;
                got.has_data   = res_if.has_data;
                got.last       = res_if.last;
                got.bad_length = res_if.bad_length;
                results_checked++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: %s", describe_result(got));
                end else begin
                    want = expected_results.pop_front();
                    if (got.board_code !== want.board_code ||
                        got.identified !== want.identified ||
                        got.message_id !== want.message_id ||
                        got.data_byte  !== want.data_byte  ||
                        got.has_data   !== want.has_data   ||
                        got.last       !== want.last       ||
                        got.bad_length !== want.bad_length) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d expected: %s", results_checked,
                                     describe_result(want));
                            $display("result %0d actual:   %s", results_checked,
                                     describe_result(got));
                        end
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready) id_code = cfg_if.board_id_code;
            if (rx_if.valid && rx_if.ready) begin
                rx_taken = 1'b1;
                words_taken++;
                deframe_word(rx_if.rx_byte);
            end
        end
    end

    initial begin
        id_code     = 8'h00;
        ph          = PH_LEN_LO;
        len_lo      = 8'h00;
        left        = 16'd0;
        frame_id    = 8'h00;
        capture     = 1'b0;
        board_value = 8'h00;
        board_known = 1'b0;
        rx_if.valid          = 1'b0;
        rx_if.rx_byte        = 8'h00;
        cfg_if.valid         = 1'b0;
        cfg_if.board_id_code = 8'h00;
        res_if.ready         = 1'b0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 32;
        recv_stall_pct = 67;
        add_frame(16'd0, 8'h00);
        add_frame(16'd1, 8'h5A);
        add_frame(16'd1, 8'h00);
        // board id frame under the reset code
        add_word(8'h02); add_word(8'h00); add_word(8'h00); add_word(8'hA5);
        add_frame(16'd3, 8'h00);
        add_frame(16'd2, 8'hFF);
        add_word(8'h05); add_word(8'h00); add_word(8'hFF);
        add_word(8'h00); add_word(8'hFF); add_word(8'h55); add_word(8'hAA);
        add_frame(16'd0, 8'h00);
        // code changes between identifier and payload word
        add_word(8'h02); add_word(8'h00); add_word(8'h77);
        wait_drained();
        write_board_id_code(8'h77);
        add_word(8'h99);
        add_word(8'h02); add_word(8'h00); add_word(8'h77);
        wait_drained();
        write_board_id_code(8'h12);
        add_word(8'hC3);
        add_frame(16'h0100, 8'h80);
        add_frame(16'd2, 8'h12);
        wait_drained();

        write_board_id_code(8'hFF);
        run_random_phase(32, 67, 540);
        write_board_id_code(8'($urandom_range(254, 1)));
        run_random_phase(67, 32, 540);
        write_board_id_code(8'h00);
        run_random_phase(0, 0, 540);

        repeat (8) @(posedge i_clk);
        $display("%0d words in, %0d results checked over %0d frames (%0d zero-length drops)",
                 words_taken, results_checked, frames_done, dropped);
        $display("%0d board id captures, %0d code writes, %0d mismatches",
                 captured, cfg_writes, mismatches);
        if (mismatches == 0) begin
            $display("length_prefixed_frame_deframer: match");
        end else begin
            $display("length_prefixed_frame_deframer: mismatch");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("length_prefixed_frame_deframer: mismatch");
        $finish;
    end

endmodule
